@@ rtl/csvp_pkg.sv @@
// shared types, codes and constants of the csv record parser
// no dependencies; imported by every module of the block
package csvp_pkg;

  // queue depth between the front and the engine, and in front of the result ports
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int unsigned FLD_W = 11;
  localparam int unsigned BCNT_W = 21;
  localparam int unsigned REC_W = 32;
  localparam int unsigned CFG_W = 21;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [2:0] kind_t;
  typedef logic [2:0] err_t;

  localparam kind_t KIND_BYTE   = 3'd0;
  localparam kind_t KIND_FIELD  = 3'd1;
  localparam kind_t KIND_RECORD = 3'd2;
  localparam kind_t KIND_EMPTY  = 3'd3;
  localparam kind_t KIND_ERROR  = 3'd4;

  localparam err_t ERR_CONFIG   = 3'd0;
  localparam err_t ERR_UNCLOSED = 3'd1;
  localparam err_t ERR_STRAY    = 3'd2;
  localparam err_t ERR_AFTERQ   = 3'd3;
  localparam err_t ERR_BYTES    = 3'd4;
  localparam err_t ERR_FIELDS   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_DELIM      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_LIM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIM   = 2'd3;

  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;

  localparam logic [7:0]        RST_DELIM     = 8'd44;
  localparam logic [7:0]        RST_QUOTE     = 8'd34;
  localparam logic [FLD_W-1:0]  RST_FIELD_LIM = 11'd1024;
  localparam logic [BCNT_W-1:0] RST_BYTE_LIM  = 21'd1048576;

  // one input byte after classification
  typedef struct packed {
    logic       eoi;
    logic [7:0] data;
    logic       is_delim;
    logic       is_quote;
    logic       is_eol;
    logic       is_cr;
    logic       is_lf;
    logic       cfg_bad;
  } item_t;

  // one result token
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    err_t             err;
    logic [REC_W-1:0] rec;
    logic [FLD_W-1:0] fld;
  } result_t;

endpackage

@@ rtl/csvp_front.sv @@
// front of the csv record parser: accepts bytes, classifies them, queues them
// depends on csvp_pkg
module csvp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 byte_in,
  input  logic                       end_of_input,
  input  logic [7:0]                 delimiter_char,
  input  logic [7:0]                 quote_char,
  input  logic [csvp_pkg::FLD_W-1:0] field_limit,
  input  logic                       item_pop,
  output logic                       item_empty,
  output csvp_pkg::item_t            item
);
  import csvp_pkg::*;

  item_t                q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic [Q_CNT_W-1:0]   count_next;
  logic                 wr_en;
  logic                 rd_en;
  item_t                cls;

  // classification against the current configuration
  always_comb begin
    cls.eoi      = end_of_input;
    cls.data     = byte_in;
    cls.is_delim = (byte_in == delimiter_char);
    cls.is_quote = (byte_in == quote_char);
    cls.is_cr    = (byte_in == CH_CR);
    cls.is_lf    = (byte_in == CH_LF);
    cls.is_eol   = (byte_in == CH_CR) || (byte_in == CH_LF);
    cls.cfg_bad  = (delimiter_char == quote_char) ||
                   (delimiter_char == CH_CR) || (delimiter_char == CH_LF) ||
                   (quote_char == CH_CR) || (quote_char == CH_LF) ||
                   (field_limit == '0);
  end

  assign full       = (count == Q_CNT_W'(Q_DEPTH));
  assign item_empty = (count == '0);
  assign wr_en      = push && !full;
  assign rd_en      = item_pop && !item_empty;
  assign item       = q[rd_ptr];

  always_comb begin
    case ({wr_en, rd_en})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= cls;
    end
  end

endmodule

@@ rtl/csvp_engine.sv @@
// parse engine of the csv record parser: record state machine and limit checks
// depends on csvp_pkg; fed by csvp_front, drains into csvp_result_queue
module csvp_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  csvp_pkg::item_t             item,
  input  logic                        item_empty,
  output logic                        item_pop,
  input  logic [csvp_pkg::FLD_W-1:0]  field_limit,
  input  logic [csvp_pkg::BCNT_W-1:0] record_byte_limit,
  output logic                        res_push,
  output csvp_pkg::result_t           res,
  input  logic                        res_full
);
  import csvp_pkg::*;

  localparam logic [1:0] ST_START = 2'd0;
  localparam logic [1:0] ST_UNQ   = 2'd1;
  localparam logic [1:0] ST_QUO   = 2'd2;
  localparam logic [1:0] ST_AFTER = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic              skip_lf;
  logic              skip_lf_next;
  logic              has_input;
  logic              has_input_next;
  logic [BCNT_W-1:0] byte_count;
  logic [BCNT_W-1:0] byte_count_next;
  logic [FLD_W-1:0]  field_count;
  logic [FLD_W-1:0]  field_count_next;
  logic [REC_W-1:0]  records_done;
  logic [REC_W-1:0]  records_done_next;

  logic              go;
  logic              byte_ok;
  logic              field_ok;
  logic              restart;
  logic              emit;
  kind_t             emit_kind;
  err_t              emit_err;
  logic [7:0]        emit_data;

  assign go       = !item_empty && !res_full;
  assign item_pop = go;
  assign byte_ok  = (byte_count < record_byte_limit);
  assign field_ok = (field_count < field_limit);

  always_comb begin
    state_next        = state;
    skip_lf_next      = skip_lf;
    has_input_next    = has_input;
    byte_count_next   = byte_count;
    field_count_next  = field_count;
    records_done_next = records_done;
    restart           = 1'b0;
    emit              = 1'b0;
    emit_kind         = KIND_BYTE;
    emit_err          = ERR_CONFIG;
    emit_data         = '0;

    if (go) begin
      if (skip_lf) begin
        skip_lf_next = 1'b0;
      end
      if (skip_lf && !item.eoi && item.is_lf) begin
        // lf right after a cr line end is swallowed
      end else if (item.cfg_bad) begin
        emit = 1'b1; emit_kind = KIND_ERROR; emit_err = ERR_CONFIG; restart = 1'b1;
      end else if (item.eoi) begin
        if (state == ST_QUO) begin
          emit = 1'b1; emit_kind = KIND_ERROR; emit_err = ERR_UNCLOSED; restart = 1'b1;
        end else if (!has_input) begin
          emit = 1'b1; emit_kind = KIND_EMPTY; restart = 1'b1;
        end else if (!field_ok) begin
          emit = 1'b1; emit_kind = KIND_ERROR; emit_err = ERR_FIELDS; restart = 1'b1;
        end else begin
          emit = 1'b1; emit_kind = KIND_RECORD; restart = 1'b1;
          records_done_next = records_done + 1'b1;
        end
      end else begin
        has_input_next = 1'b1;
        if (state == ST_QUO) begin
          if (!byte_ok) begin
            emit = 1'b1; emit_kind = KIND_ERROR; emit_err = ERR_BYTES; restart = 1'b1;
          end else begin
            byte_count_next = byte_count + 1'b1;
            if (item.is_quote) begin
              state_next = ST_AFTER;
            end else begin
              emit = 1'b1; emit_kind = KIND_BYTE; emit_data = item.data;
            end
          end
        end else if (state == ST_AFTER && item.is_quote) begin
          // escaped quote
          if (!byte_ok) begin
            emit = 1'b1; emit_kind = KIND_ERROR; emit_err = ERR_BYTES; restart = 1'b1;
          end else begin
            byte_count_next = byte_count + 1'b1;
            state_next = ST_QUO;
            emit = 1'b1; emit_kind = KIND_BYTE; emit_data = item.data;
          end
        end else if (item.is_delim) begin
          if (!byte_ok) begin
            emit = 1'b1; emit_kind = KIND_ERROR; emit_err = ERR_BYTES; restart = 1'b1;
          end else if (!field_ok) begin
            emit = 1'b1; emit_kind = KIND_ERROR; emit_err = ERR_FIELDS; restart = 1'b1;
          end else begin
            byte_count_next  = byte_count + 1'b1;
            field_count_next = field_count + 1'b1;
            state_next = ST_START;
            emit = 1'b1; emit_kind = KIND_FIELD;
          end
        end else if (item.is_quote) begin
          // start or unquoted state here
          if (state == ST_UNQ) begin
            emit = 1'b1; emit_kind = KIND_ERROR; emit_err = ERR_STRAY; restart = 1'b1;
          end else if (!byte_ok) begin
            emit = 1'b1; emit_kind = KIND_ERROR; emit_err = ERR_BYTES; restart = 1'b1;
          end else begin
            byte_count_next = byte_count + 1'b1;
            state_next = ST_QUO;
          end
        end else if (item.is_eol) begin
          if (item.is_cr) begin
            skip_lf_next = 1'b1;
          end
          if (!field_ok) begin
            emit = 1'b1; emit_kind = KIND_ERROR; emit_err = ERR_FIELDS; restart = 1'b1;
          end else begin
            emit = 1'b1; emit_kind = KIND_RECORD; restart = 1'b1;
            records_done_next = records_done + 1'b1;
          end
        end else if (state == ST_AFTER) begin
          emit = 1'b1; emit_kind = KIND_ERROR; emit_err = ERR_AFTERQ; restart = 1'b1;
        end else if (!byte_ok) begin
          emit = 1'b1; emit_kind = KIND_ERROR; emit_err = ERR_BYTES; restart = 1'b1;
        end else begin
          byte_count_next = byte_count + 1'b1;
          state_next = ST_UNQ;
          emit = 1'b1; emit_kind = KIND_BYTE; emit_data = item.data;
        end
      end

      if (restart) begin
        state_next       = ST_START;
        has_input_next   = 1'b0;
        byte_count_next  = '0;
        field_count_next = '0;
      end
    end
  end

  always_comb begin
    res_push = emit;
    res.kind = emit_kind;
    res.data = emit_data;
    res.err  = (emit_kind == KIND_ERROR) ? emit_err : ERR_CONFIG;
    res.rec  = records_done + 1'b1;
    res.fld  = field_count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_START;
      skip_lf      <= 1'b0;
      has_input    <= 1'b0;
      byte_count   <= '0;
      field_count  <= '0;
      records_done <= '0;
    end else begin
      state        <= state_next;
      skip_lf      <= skip_lf_next;
      has_input    <= has_input_next;
      byte_count   <= byte_count_next;
      field_count  <= field_count_next;
      records_done <= records_done_next;
    end
  end

endmodule

@@ rtl/csvp_result_queue.sv @@
// result queue of the csv record parser: holds tokens until popped
// depends on csvp_pkg
module csvp_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_push,
  input  csvp_pkg::result_t res,
  output logic              res_full,
  input  logic              pop,
  output logic              empty,
  output csvp_pkg::result_t head
);
  import csvp_pkg::*;

  result_t            q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic [Q_CNT_W-1:0] count_next;
  logic               wr_en;
  logic               rd_en;

  assign res_full = (count == Q_CNT_W'(Q_DEPTH));
  assign empty    = (count == '0);
  assign wr_en    = res_push && !res_full;
  assign rd_en    = pop && !empty;
  assign head     = q[rd_ptr];

  always_comb begin
    case ({wr_en, rd_en})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= res;
    end
  end

endmodule

@@ rtl/csv_record_parser_top.sv @@
// top level of the csv record parser: configuration registers and the three stages
// depends on csvp_pkg, csvp_front, csvp_engine, csvp_result_queue
//
// strict csv tokenizer taking one byte (or an end-of-stream mark) per push
// transaction and giving at most one token per byte on the pop side: a field
// byte, a field end, a record end, an empty stream end, or a numbered error.
// the block sustains one transaction per clock on both sides while pop keeps
// up; the limit is the parse engine, which updates the record state for one
// byte each cycle while the result queue has room. a pushed byte is classified
// and written into a two-entry input queue; the engine processes it from the
// queue head and its token is registered into the result queue, which drives
// the result ports. each side stalls on its own: full rises only when both
// queues back up behind a stalled pop. configuration is written through a
// plain write port and must only change while no transaction is in flight;
// there is no read-back and no startup sweep after reset
module csv_record_parser_top (
  input  logic                           clk,
  input  logic                           rst,
  // input side
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     byte_in,
  input  logic                           end_of_input,
  // result side
  input  logic                           pop,
  output logic                           empty,
  output logic [2:0]                     kind,
  output logic [7:0]                     data_byte,
  output logic [2:0]                     error_code,
  output logic [31:0]                    record_number,
  output logic [10:0]                    field_number,
  // configuration
  input  logic                           cfg_write,
  input  logic [csvp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csvp_pkg::CFG_W-1:0]     cfg_data
);
  import csvp_pkg::*;

  logic [7:0]        delimiter_char;
  logic [7:0]        quote_char;
  logic [FLD_W-1:0]  field_limit;
  logic [BCNT_W-1:0] record_byte_limit;

  item_t             item;
  logic              item_empty;
  logic              item_pop;
  result_t           res;
  logic              res_push;
  logic              res_full;
  result_t           head;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char    <= RST_DELIM;
      quote_char        <= RST_QUOTE;
      field_limit       <= RST_FIELD_LIM;
      record_byte_limit <= RST_BYTE_LIM;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DELIM:     delimiter_char    <= cfg_data[7:0];
        CFG_QUOTE:     quote_char        <= cfg_data[7:0];
        CFG_FIELD_LIM: field_limit       <= cfg_data[FLD_W-1:0];
        CFG_BYTE_LIM:  record_byte_limit <= cfg_data[BCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // classify and queue incoming bytes
  csvp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .byte_in        (byte_in),
    .end_of_input   (end_of_input),
    .delimiter_char (delimiter_char),
    .quote_char     (quote_char),
    .field_limit    (field_limit),
    .item_pop       (item_pop),
    .item_empty     (item_empty),
    .item           (item)
  );

  // record state machine, one byte per cycle when the result queue has room
  csvp_engine u_engine (
    .clk               (clk),
    .rst               (rst),
    .item              (item),
    .item_empty        (item_empty),
    .item_pop          (item_pop),
    .field_limit       (field_limit),
    .record_byte_limit (record_byte_limit),
    .res_push          (res_push),
    .res               (res),
    .res_full          (res_full)
  );

  // tokens wait here for the consumer
  csvp_result_queue u_result_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign kind          = head.kind;
  assign data_byte     = head.data;
  assign error_code    = head.err;
  assign record_number = head.rec;
  assign field_number  = head.fld;

endmodule
